// ===== design/bre_pkg.sv =====
// Shared types and constants for the battery resistance estimator.
// Used by bre_div, bre_dp, bre_ctrl and the top level. No dependencies.
`default_nettype none
package bre_pkg;

    localparam int ACC_W  = 82;   // filter numerator accumulator
    localparam int PROD_W = 66;   // 33 x 33 signed product
    localparam int DIV_W  = 80;   // divider dividend / quotient
    localparam int DVS_W  = 33;   // divider divisor magnitude
    localparam int CNT_W  = 7;

    localparam logic [CNT_W-1:0] RAW_BITS  = 7'd42;
    localparam logic [CNT_W-1:0] FILT_BITS = 7'd80;
    localparam logic [CNT_W-1:0] HLT_BITS  = 7'd49;

    localparam logic [2:0] CFG_A1   = 3'd0;
    localparam logic [2:0] CFG_A2   = 3'd1;
    localparam logic [2:0] CFG_B1   = 3'd2;
    localparam logic [2:0] CFG_B2   = 3'd3;
    localparam logic [2:0] CFG_CMIN = 3'd4;
    localparam logic [2:0] CFG_CHI  = 3'd5;
    localparam logic [2:0] CFG_CLO  = 3'd6;
    localparam logic [2:0] CFG_WLEN = 3'd7;

    localparam logic [31:0] RST_A1   = 32'd1073741824;
    localparam logic [31:0] RST_A2   = 32'hC00083C3;
    localparam logic [31:0] RST_B1   = 32'd16866;
    localparam logic [31:0] RST_B2   = 32'd16866;
    localparam logic [30:0] RST_CMIN = 31'd100;
    localparam logic [15:0] RST_CHI  = 16'd52429;
    localparam logic [15:0] RST_CLO  = 16'd13107;
    localparam logic [17:0] RST_WLEN = 18'd250000;

    localparam logic [31:0] RST_LAST_I = 32'd1000;
    localparam logic [47:0] RST_FILT   = 48'd1179648000;
    localparam logic [31:0] RST_RAW    = 32'd18000;
    localparam logic [31:0] ONE_Q16    = 32'd65536;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RAW_START,
        OP_RAW_TAKE,
        OP_RAW_HOLD,
        OP_MUL,
        OP_FDIV_START,
        OP_FILT_TAKE,
        OP_HEALTH,
        OP_HDIV_START,
        OP_HEALTH_TAKE,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] mul_step;
    } t_cmd;

    typedef struct packed {
        logic inh;
        logic a1_zero;
        logic di_zero;
        logic div_busy;
        logic need_hdiv;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/bre_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Dividend arrives left-aligned for the requested bit count. Uses bre_pkg.
`default_nettype none
module bre_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [bre_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [bre_pkg::DVS_W-1:0]   i_divisor,
    input  wire logic [bre_pkg::CNT_W-1:0]   i_nbits,
    output logic                             o_busy,
    output logic [bre_pkg::DIV_W-1:0]        o_quotient
);

    logic [bre_pkg::DIV_W-1:0] r_work;
    logic [bre_pkg::DVS_W-1:0] r_rem;
    logic [bre_pkg::DVS_W-1:0] r_dvs;
    logic [bre_pkg::CNT_W-1:0] r_cnt;
    logic                      r_busy;

    logic [bre_pkg::DVS_W:0]   rem_sh;
    logic [bre_pkg::DVS_W:0]   rem_sub;
    logic                      ge;

    assign rem_sh  = {r_rem, r_work[bre_pkg::DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign ge      = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_nbits;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[bre_pkg::DIV_W-2:0], ge};
            r_rem  <= ge ? rem_sub[bre_pkg::DVS_W-1:0] : rem_sh[bre_pkg::DVS_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_work;

endmodule
`default_nettype wire

// ===== design/bre_dp.sv =====
// Datapath: config registers, estimator state, shared multiplier and divider.
// Driven by bre_ctrl commands. Uses bre_pkg and bre_div.
`default_nettype none
module bre_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic signed [31:0]   i_voltage,
    input  wire logic signed [31:0]   i_current,
    input  wire logic [15:0]          i_state_of_charge,
    input  wire logic                 i_out_ready,
    input  wire bre_pkg::t_cmd        i_cmd,
    output bre_pkg::t_stat            o_stat,
    output logic                      o_out_valid,
    output logic signed [31:0]        o_resistance,
    output logic signed [31:0]        o_health
);

    logic [31:0] r_a1, r_a2, r_b1, r_b2;
    logic [30:0] r_cmin;
    logic [15:0] r_chi, r_clo;
    logic [17:0] r_wlen;

    logic [31:0] r_last_v, r_last_c;
    logic [32:0] r_du, r_di;
    logic        r_inh;
    logic [47:0] r_filt;
    logic [31:0] r_last_raw, r_raw, r_ref, r_health;
    logic        r_cap;
    logic [17:0] r_warm;
    logic [bre_pkg::ACC_W-1:0]  r_acc;
    logic [bre_pkg::PROD_W-1:0] r_prod;
    logic        r_qneg;
    logic        r_out_valid;
    logic [31:0] r_res_out, r_hlt_out;

    // sample differences and inhibit
    logic [32:0] du_n, di_n, adi_n;
    logic        inh_n;
    assign du_n  = {i_voltage[31], i_voltage} - {r_last_v[31], r_last_v};
    assign di_n  = {i_current[31], i_current} - {r_last_c[31], r_last_c};
    assign adi_n = di_n[32] ? (33'd0 - di_n) : di_n;
    assign inh_n = (adi_n < {2'b00, r_cmin}) || (i_state_of_charge > r_chi)
                   || (i_state_of_charge < r_clo);

    // raw resistance division operands
    logic [32:0] mag_du, mag_di;
    logic [42:0] raw_num;
    logic        raw_neg;
    assign mag_du  = r_du[32] ? (33'd0 - r_du) : r_du;
    assign mag_di  = r_di[32] ? (33'd0 - r_di) : r_di;
    assign raw_num = {10'd0, mag_du} * 43'd1000;
    assign raw_neg = (!r_du[32] && (r_du != 33'd0)) ^ r_di[32];

    // filter division operands
    logic [bre_pkg::ACC_W-1:0] acc_mag;
    logic [32:0]               mag_a1;
    assign acc_mag = r_acc[bre_pkg::ACC_W-1] ? ('0 - r_acc) : r_acc;
    assign mag_a1  = r_a1[31] ? (33'd0 - {1'b1, r_a1}) : {1'b0, r_a1};

    // health division operands
    logic [31:0] res;
    logic [32:0] dres, mag_dres, mag_ref;
    assign res      = r_filt[47:16];
    assign dres     = {res[31], res} - {r_ref[31], r_ref};
    assign mag_dres = dres[32] ? (33'd0 - dres) : dres;
    assign mag_ref  = r_ref[31] ? (33'd0 - {1'b1, r_ref}) : {1'b0, r_ref};

    logic warm_run;
    assign warm_run = r_warm < r_wlen;

    // shared divider
    logic                        div_start, div_busy;
    logic [bre_pkg::DIV_W-1:0]   div_dvd, q;
    logic [bre_pkg::DVS_W-1:0]   div_dvs;
    logic [bre_pkg::CNT_W-1:0]   div_bits;

    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        div_bits  = '0;
        case (i_cmd.op)
            bre_pkg::OP_RAW_START: begin
                div_start = 1'b1;
                div_dvd   = {raw_num[41:0], 38'd0};
                div_dvs   = mag_di;
                div_bits  = bre_pkg::RAW_BITS;
            end
            bre_pkg::OP_FDIV_START: begin
                div_start = 1'b1;
                div_dvd   = acc_mag[bre_pkg::DIV_W-1:0];
                div_dvs   = mag_a1;
                div_bits  = bre_pkg::FILT_BITS;
            end
            bre_pkg::OP_HDIV_START: begin
                div_start = 1'b1;
                div_dvd   = {mag_dres, 16'd0, 31'd0};
                div_dvs   = mag_ref;
                div_bits  = bre_pkg::HLT_BITS;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    bre_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_nbits    (div_bits),
        .o_busy     (div_busy),
        .o_quotient (q)
    );

    // quotient post-processing
    logic [31:0] raw_q;
    logic [47:0] filt_q;
    logic [50:0] hq_s;
    logic [51:0] h_full;
    logic [31:0] hlt_q;

    always_comb begin
        if (!r_qneg) begin
            raw_q  = (|q[79:31]) ? 32'h7FFF_FFFF : q[31:0];
            filt_q = (|q[79:47]) ? 48'h7FFF_FFFF_FFFF : q[47:0];
        end else begin
            raw_q  = ((|q[79:32]) || (q[31] && (|q[30:0]))) ? 32'h8000_0000
                     : (32'd0 - q[31:0]);
            filt_q = ((|q[79:48]) || (q[47] && (|q[46:0]))) ? 48'h8000_0000_0000
                     : (48'd0 - q[47:0]);
        end
        hq_s   = r_qneg ? (51'd0 - {2'b00, q[48:0]}) : {2'b00, q[48:0]};
        h_full = {20'd0, bre_pkg::ONE_Q16} - {hq_s[50], hq_s};
        if (!h_full[51] && (|h_full[50:31])) begin
            hlt_q = 32'h7FFF_FFFF;
        end else if (h_full[51] && !(&h_full[50:31])) begin
            hlt_q = 32'h8000_0000;
        end else begin
            hlt_q = h_full[31:0];
        end
    end

    // shared multiplier
    logic signed [32:0] mul_a, mul_b, na2;
    logic [bre_pkg::PROD_W-1:0] n_prod;
    logic [bre_pkg::ACC_W-1:0]  prod_x;
    assign na2 = 33'sd0 - $signed({r_a2[31], r_a2});

    always_comb begin
        case (i_cmd.mul_step)
            3'd0: begin
                mul_a = $signed({r_b1[31], r_b1});
                mul_b = $signed({r_raw[31], r_raw});
            end
            3'd1: begin
                mul_a = $signed({r_b2[31], r_b2});
                mul_b = $signed({r_last_raw[31], r_last_raw});
            end
            3'd2: begin
                mul_a = na2;
                mul_b = $signed({9'd0, r_filt[23:0]});
            end
            3'd3: begin
                mul_a = na2;
                mul_b = $signed({{9{r_filt[47]}}, r_filt[47:24]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;
    assign prod_x = {{(bre_pkg::ACC_W - bre_pkg::PROD_W){r_prod[bre_pkg::PROD_W-1]}}, r_prod};

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1   <= bre_pkg::RST_A1;
            r_a2   <= bre_pkg::RST_A2;
            r_b1   <= bre_pkg::RST_B1;
            r_b2   <= bre_pkg::RST_B2;
            r_cmin <= bre_pkg::RST_CMIN;
            r_chi  <= bre_pkg::RST_CHI;
            r_clo  <= bre_pkg::RST_CLO;
            r_wlen <= bre_pkg::RST_WLEN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bre_pkg::CFG_A1:   r_a1   <= i_cfg_data;
                bre_pkg::CFG_A2:   r_a2   <= i_cfg_data;
                bre_pkg::CFG_B1:   r_b1   <= i_cfg_data;
                bre_pkg::CFG_B2:   r_b2   <= i_cfg_data;
                bre_pkg::CFG_CMIN: r_cmin <= i_cfg_data[30:0];
                bre_pkg::CFG_CHI:  r_chi  <= i_cfg_data[15:0];
                bre_pkg::CFG_CLO:  r_clo  <= i_cfg_data[15:0];
                bre_pkg::CFG_WLEN: r_wlen <= i_cfg_data[17:0];
                default:           r_a1   <= r_a1;
            endcase
        end
    end

    // estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_v    <= '0;
            r_last_c    <= bre_pkg::RST_LAST_I;
            r_filt      <= bre_pkg::RST_FILT;
            r_last_raw  <= bre_pkg::RST_RAW;
            r_ref       <= '0;
            r_cap       <= 1'b0;
            r_warm      <= '0;
            r_health    <= bre_pkg::ONE_Q16;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == bre_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                bre_pkg::OP_LOAD: begin
                    r_du     <= du_n;
                    r_di     <= di_n;
                    r_inh    <= inh_n;
                    r_last_v <= i_voltage;
                    r_last_c <= i_current;
                end
                bre_pkg::OP_RAW_START: r_qneg <= raw_neg;
                bre_pkg::OP_RAW_TAKE:  r_raw  <= raw_q;
                bre_pkg::OP_RAW_HOLD:  r_raw  <= res;
                bre_pkg::OP_MUL: begin
                    r_prod <= n_prod;
                    case (i_cmd.mul_step)
                        3'd1:    r_acc <= prod_x;
                        3'd2:    r_acc <= (r_acc + prod_x) << 16;
                        3'd3:    r_acc <= r_acc + prod_x;
                        3'd4:    r_acc <= r_acc + (prod_x << 24);
                        default: r_acc <= r_acc;
                    endcase
                end
                bre_pkg::OP_FDIV_START: r_qneg <= r_acc[bre_pkg::ACC_W-1] ^ r_a1[31];
                bre_pkg::OP_FILT_TAKE: begin
                    r_filt     <= filt_q;
                    r_last_raw <= r_raw;
                end
                bre_pkg::OP_HEALTH: begin
                    if (warm_run) begin
                        r_warm   <= r_warm + 1'b1;
                        r_health <= bre_pkg::ONE_Q16;
                    end else if (!r_inh) begin
                        if (!r_cap) begin
                            r_ref    <= res;
                            r_cap    <= 1'b1;
                            r_health <= bre_pkg::ONE_Q16;
                        end else if (r_ref == 32'd0) begin
                            r_health <= bre_pkg::ONE_Q16;
                        end
                    end
                end
                bre_pkg::OP_HDIV_START:  r_qneg   <= dres[32] ^ r_ref[31];
                bre_pkg::OP_HEALTH_TAKE: r_health <= hlt_q;
                bre_pkg::OP_OUT: begin
                    r_res_out   <= res;
                    r_hlt_out   <= r_health;
                end
                default: r_warm <= r_warm;
            endcase
        end
    end

    assign o_stat.inh       = r_inh;
    assign o_stat.a1_zero   = (r_a1 == 32'd0);
    assign o_stat.di_zero   = (r_di == 33'd0);
    assign o_stat.div_busy  = div_busy;
    assign o_stat.need_hdiv = !warm_run && !r_inh && r_cap && (r_ref != 32'd0);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_resistance = r_res_out;
    assign o_health     = r_hlt_out;

endmodule
`default_nettype wire

// ===== design/bre_ctrl.sv =====
// Controller state machine sequencing the estimator datapath per sample.
// Issues t_cmd, reads t_stat. Uses bre_pkg.
`default_nettype none
module bre_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire bre_pkg::t_stat i_stat,
    output logic                o_in_ready,
    output bre_pkg::t_cmd       o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CHECK    = 9'b000000010,
        S_RAW_WAIT = 9'b000000100,
        S_MUL      = 9'b000001000,
        S_FDIV     = 9'b000010000,
        S_FWAIT    = 9'b000100000,
        S_HEALTH   = 9'b001000000,
        S_HWAIT    = 9'b010000000,
        S_OUT      = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_cmd.op       = bre_pkg::OP_NONE;
        o_cmd.mul_step = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = bre_pkg::OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_step = 3'd0;
                if (i_stat.inh || i_stat.a1_zero) begin
                    n_state = S_HEALTH;
                end else if (i_stat.di_zero) begin
                    o_cmd.op = bre_pkg::OP_RAW_HOLD;
                    n_state  = S_MUL;
                end else begin
                    o_cmd.op = bre_pkg::OP_RAW_START;
                    n_state  = S_RAW_WAIT;
                end
            end
            S_RAW_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = bre_pkg::OP_RAW_TAKE;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = bre_pkg::OP_MUL;
                n_step   = r_step + 1'b1;
                if (r_step == 3'd4) begin
                    n_state = S_FDIV;
                end
            end
            S_FDIV: begin
                o_cmd.op = bre_pkg::OP_FDIV_START;
                n_state  = S_FWAIT;
            end
            S_FWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = bre_pkg::OP_FILT_TAKE;
                    n_state  = S_HEALTH;
                end
            end
            S_HEALTH: begin
                if (i_stat.need_hdiv) begin
                    o_cmd.op = bre_pkg::OP_HDIV_START;
                    n_state  = S_HWAIT;
                end else begin
                    o_cmd.op = bre_pkg::OP_HEALTH;
                    n_state  = S_OUT;
                end
            end
            S_HWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = bre_pkg::OP_HEALTH_TAKE;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = bre_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

// ===== design/battery_resistance_estimator.sv =====
// Battery internal-resistance estimator, top level: bre_ctrl plus bre_dp.
// One sample in flight. Each sample needs up to 42-, 80- and 49-bit divisions
// on one radix-2 divider plus 5 multiply steps; an inhibited one skips them.
// New input waits for the result write, which stalls until the last one is taken.
// Synchronous active-low reset restores register defaults and estimator state.
`default_nettype none
module battery_resistance_estimator (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic signed [31:0]  i_voltage,
    input  wire logic signed [31:0]  i_current,
    input  wire logic [15:0]         i_state_of_charge,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [31:0]       o_resistance,
    output logic signed [31:0]       o_health
);

    bre_pkg::t_cmd  cmd;
    bre_pkg::t_stat stat;

    bre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    bre_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_voltage         (i_voltage),
        .i_current         (i_current),
        .i_state_of_charge (i_state_of_charge),
        .i_out_ready       (i_out_ready),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .o_resistance      (o_resistance),
        .o_health          (o_health)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input transfer while a sample is in flight");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == bre_pkg::OP_OUT) |-> stat.out_free)
        else $error("result written over an untaken result");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cmd.op == bre_pkg::OP_RAW_START) || (cmd.op == bre_pkg::OP_FDIV_START)
         || (cmd.op == bre_pkg::OP_HDIV_START)) |-> !stat.div_busy)
        else $error("divider started while busy");

endmodule
`default_nettype wire
